// ===== hw/rtl/irt_pkg.sv =====
package irt_pkg;

   localparam int SLOT_COUNT = 8;
   localparam int SLOT_BITS = $clog2(SLOT_COUNT);
   localparam int MAX_BLOCKS = 1024;
   localparam int MAP_WORDS = (MAX_BLOCKS + 63) / 64;
   localparam int WORD_BITS = $clog2(MAP_WORDS);
   localparam int MAP_DEPTH = SLOT_COUNT * MAP_WORDS;
   localparam int BLK_BITS = $clog2(MAX_BLOCKS + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_BITS = $clog2(QUEUE_DEPTH);

   localparam logic [2:0] ST_WHOLE = 3'd0;
   localparam logic [2:0] ST_PENDING = 3'd1;
   localparam logic [2:0] ST_DONE = 3'd2;
   localparam logic [2:0] ST_EXPIRED = 3'd3;
   localparam logic [2:0] ST_FULL = 3'd4;
   localparam logic [2:0] ST_BAD = 3'd5;

   localparam logic [7:0] TIMER_RESET = 8'd15;

   typedef struct packed {
      logic        operation;
      logic [31:0] source_address;
      logic [31:0] destination_address;
      logic [7:0]  protocol_number;
      logic [15:0] datagram_id;
      logic [12:0] fragment_offset;
      logic        more_fragments;
      logic [3:0]  header_words;
      logic [15:0] total_length;
      logic [7:0]  time_to_live;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  slot_index;
      logic [13:0] byte_start;
      logic [13:0] byte_end;
      logic [13:0] reassembled_length;
      logic        last_result;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_TICK,
      KIND_BAD,
      KIND_WHOLE,
      KIND_FRAG
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [63:0]           akey;
      logic [23:0]           pkey;
      logic                  first;
      logic                  mf;
      logic [3:0]            hw;
      logic [7:0]            ttl;
      logic [BLK_BITS-1:0]   fo_blk;
      logic [BLK_BITS-1:0]   end_blk;
      logic [13:0]           byte_start;
      logic [13:0]           byte_end;
   } cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MATCH,
      S_RD,
      S_WR,
      S_FIN,
      S_TICK
   } state_type;

endpackage

// ===== hw/rtl/ipv4_reassembly_tracker.sv =====
// Channel   Ports                              Transaction
// request   req_push, req_full, req_data       push && !full
// response  rsp_empty, rsp_pop, rsp_data       pop && !empty
// config    csr_write, csr_data                csr_write
//
// A fragment passes through match and allocate, then a read and a write
// of each of the 16 bitmap words of its slot in the bitmap RAM, then the result.
// A tick is taken from the queue, then each slot is visited in turn.
// Other items are taken from the queue and give their result in the match state.
// Reset clears the slot table, the request queue and the result register.
// Up to four classified items wait while the result register is stalled.
module ipv4_reassembly_tracker import irt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  req_type    req_data,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output rsp_type    rsp_data,
   input  logic       csr_write,
   input  logic [7:0] csr_data
);

   cmd_type cmd;
   cmd_type q_data;
   logic    q_empty;
   logic    q_pop;

   irt_front u_front (
      .req_data(req_data),
      .cmd(cmd)
   );

   irt_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(req_push),
      .push_data(cmd),
      .full(req_full),
      .pop(q_pop),
      .pop_data(q_data),
      .empty(q_empty)
   );

   irt_back u_back (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_data(csr_data),
      .q_empty(q_empty),
      .q_data(q_data),
      .q_pop(q_pop),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data)
   );

endmodule

// ===== hw/rtl/irt_ram.sv =====
module irt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/irt_front.sv =====
module irt_front import irt_pkg::*; (
   input  req_type req_data,
   output cmd_type cmd
);

   logic [15:0] hdr_bytes;
   logic        bad_hdr;
   logic [15:0] payload;
   logic [13:0] blocks;
   logic [16:0] blocks_sum;
   logic [14:0] end_sum;
   logic        range_bad;
   logic        whole;
   logic [15:0] start_wide;
   logic [15:0] end_wide;

   always_comb begin
      hdr_bytes = {10'd0, req_data.header_words, 2'b00};
      bad_hdr = (req_data.header_words < 4'd5) || (req_data.total_length < hdr_bytes);
      payload = req_data.total_length - hdr_bytes;
      blocks_sum = {1'b0, payload} + 17'd7;
      blocks = blocks_sum[16:3];
      end_sum = {2'b00, req_data.fragment_offset} + {1'b0, blocks};
      range_bad = end_sum > 15'(MAX_BLOCKS);
      whole = (req_data.fragment_offset == 13'd0) && !req_data.more_fragments;
      start_wide = {req_data.fragment_offset, 3'b000};
      end_wide = start_wide + payload;

      cmd.akey = {req_data.source_address, req_data.destination_address};
      cmd.pkey = {req_data.protocol_number, req_data.datagram_id};
      cmd.first = req_data.fragment_offset == 13'd0;
      cmd.mf = req_data.more_fragments;
      cmd.hw = req_data.header_words;
      cmd.ttl = req_data.time_to_live;
      cmd.fo_blk = req_data.fragment_offset[BLK_BITS-1:0];
      cmd.end_blk = end_sum[BLK_BITS-1:0];
      cmd.byte_start = start_wide[13:0];
      cmd.byte_end = end_wide[13:0];

      if (req_data.operation) begin
         cmd.kind = KIND_TICK;
      end else if (bad_hdr) begin
         cmd.kind = KIND_BAD;
      end else if (whole) begin
         cmd.kind = KIND_WHOLE;
      end else if (range_bad) begin
         cmd.kind = KIND_BAD;
      end else begin
         cmd.kind = KIND_FRAG;
      end
   end

endmodule

// ===== hw/rtl/irt_queue.sv =====
module irt_queue import irt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_BITS:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   always_comb begin
      full = count_ff == (QUEUE_BITS+1)'(QUEUE_DEPTH);
      empty = count_ff == '0;
      do_push = push && !full;
      do_pop = pop && !empty;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
      pop_data = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/irt_back.sv =====
module irt_back import irt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write,
   input  logic [7:0] csr_data,
   input  logic       q_empty,
   input  cmd_type    q_data,
   output logic       q_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output rsp_type    rsp_data
);

   state_type state_ff, state_in;
   cmd_type   cur_ff, cur_in;
   logic [7:0] tlb_ff;

   logic [SLOT_COUNT-1:0] in_use_ff, in_use_in;
   logic [63:0] akey_ff [SLOT_COUNT];
   logic [63:0] akey_in [SLOT_COUNT];
   logic [23:0] pkey_ff [SLOT_COUNT];
   logic [23:0] pkey_in [SLOT_COUNT];
   logic [7:0]  timer_ff [SLOT_COUNT];
   logic [7:0]  timer_in [SLOT_COUNT];
   logic [13:0] dl_ff [SLOT_COUNT];
   logic [13:0] dl_in [SLOT_COUNT];
   logic [3:0]  hw_ff [SLOT_COUNT];
   logic [3:0]  hw_in [SLOT_COUNT];
   logic [7:0]  ttl_ff [SLOT_COUNT];
   logic [7:0]  ttl_in [SLOT_COUNT];
   logic [MAP_WORDS-1:0] valid_ff [SLOT_COUNT];
   logic [MAP_WORDS-1:0] valid_in [SLOT_COUNT];

   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic [WORD_BITS-1:0] word_ff, word_in;
   logic [BLK_BITS-1:0]  need_ff, need_in;
   logic                 complete_ff, complete_in;
   logic [SLOT_BITS-1:0] tick_ff, tick_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 res_free;
   logic                 hit;
   logic [SLOT_BITS-1:0] hit_idx;
   logic                 has_free;
   logic [SLOT_BITS-1:0] free_idx;
   logic [SLOT_BITS-1:0] s;
   logic [13:0]          dl_new;
   logic [14:0]          need_sum;
   logic                 more_after;
   logic                 ram_we;
   logic                 ram_re;
   logic [SLOT_BITS+WORD_BITS-1:0] ram_addr;
   logic [63:0]          ram_q;
   logic [63:0]          old_word;
   logic [63:0]          new_word;
   logic [63:0]          set_mask;
   logic [63:0]          need_mask;
   logic [BLK_BITS-1:0]  blk;
   logic [13:0]          rlen;

   irt_ram #(.WIDTH(64), .DEPTH(MAP_DEPTH)) u_map (
      .clock(clock),
      .wr_en(ram_we),
      .wr_addr(ram_addr),
      .wr_data(new_word),
      .rd_en(ram_re),
      .rd_addr(ram_addr),
      .rd_data(ram_q)
   );

   always_comb begin
      res_free = !rsp_valid_ff || rsp_pop;
      hit = 1'b0;
      hit_idx = '0;
      has_free = 1'b0;
      free_idx = '0;
      for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
         if (in_use_ff[k] && akey_ff[k] == cur_ff.akey && pkey_ff[k] == cur_ff.pkey) begin
            hit = 1'b1;
            hit_idx = SLOT_BITS'(k);
         end
         if (!in_use_ff[k]) begin
            has_free = 1'b1;
            free_idx = SLOT_BITS'(k);
         end
      end
      more_after = 1'b0;
      for (int k = 0; k < SLOT_COUNT; k++) begin
         if (k > int'(tick_ff) && in_use_ff[k] && timer_ff[k] <= 8'd1) begin
            more_after = 1'b1;
         end
      end

      old_word = valid_ff[slot_ff][word_ff] ? ram_q : 64'd0;
      for (int i = 0; i < 64; i++) begin
         blk = {1'b0, word_ff, i[5:0]};
         set_mask[i] = (blk >= cur_ff.fo_blk) && (blk < cur_ff.end_blk);
         need_mask[i] = blk < need_ff;
      end
      new_word = old_word | set_mask;
      ram_addr = {slot_ff, word_ff};
      ram_re = state_ff == S_RD;
      ram_we = state_ff == S_WR;
      rlen = dl_ff[slot_ff] + {8'd0, hw_ff[slot_ff], 2'b00};

      state_in = state_ff;
      cur_in = cur_ff;
      in_use_in = in_use_ff;
      akey_in = akey_ff;
      pkey_in = pkey_ff;
      timer_in = timer_ff;
      dl_in = dl_ff;
      hw_in = hw_ff;
      ttl_in = ttl_ff;
      valid_in = valid_ff;
      slot_in = slot_ff;
      word_in = word_ff;
      need_in = need_ff;
      complete_in = complete_ff;
      tick_in = tick_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in = rsp_ff;
      q_pop = 1'b0;
      s = hit ? hit_idx : free_idx;
      dl_new = '0;
      need_sum = '0;

      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               cur_in = q_data;
               tick_in = '0;
               state_in = (q_data.kind == KIND_TICK) ? S_TICK : S_MATCH;
            end
         end
         S_MATCH: begin
            if (res_free) begin
               case (cur_ff.kind)
                  KIND_WHOLE: begin
                     if (hit) begin
                        in_use_in[hit_idx] = 1'b0;
                     end
                     rsp_valid_in = 1'b1;
                     rsp_in = '{ST_WHOLE, 3'(hit ? hit_idx : '0), 14'd0, 14'd0, 14'd0, 1'b1};
                     state_in = S_IDLE;
                  end
                  KIND_FRAG: begin
                     if (!hit && !has_free) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{ST_FULL, 3'd0, 14'd0, 14'd0, 14'd0, 1'b1};
                        state_in = S_IDLE;
                     end else begin
                        if (!hit) begin
                           in_use_in[s] = 1'b1;
                           akey_in[s] = cur_ff.akey;
                           pkey_in[s] = cur_ff.pkey;
                           timer_in[s] = tlb_ff;
                           dl_in[s] = '0;
                           ttl_in[s] = '0;
                           valid_in[s] = '0;
                        end
                        dl_new = cur_ff.mf ? (hit ? dl_ff[s] : 14'd0) : cur_ff.byte_end;
                        dl_in[s] = dl_new;
                        if (cur_ff.first) begin
                           hw_in[s] = cur_ff.hw;
                           ttl_in[s] = cur_ff.ttl;
                        end
                        need_sum = {1'b0, dl_new} + 15'd7;
                        need_in = need_sum[BLK_BITS+2:3];
                        slot_in = s;
                        word_in = '0;
                        complete_in = 1'b1;
                        state_in = S_RD;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in = '{ST_BAD, 3'd0, 14'd0, 14'd0, 14'd0, 1'b1};
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_RD: begin
            state_in = S_WR;
         end
         S_WR: begin
            valid_in[slot_ff][word_ff] = 1'b1;
            if ((new_word & need_mask) != need_mask) begin
               complete_in = 1'b0;
            end
            word_in = word_ff + 1'b1;
            state_in = (word_ff == WORD_BITS'(MAP_WORDS - 1)) ? S_FIN : S_RD;
         end
         S_FIN: begin
            if (res_free) begin
               rsp_valid_in = 1'b1;
               if (dl_ff[slot_ff] != 14'd0 && complete_ff) begin
                  in_use_in[slot_ff] = 1'b0;
                  rsp_in = '{ST_DONE, 3'(slot_ff), cur_ff.byte_start, cur_ff.byte_end,
                             rlen, 1'b1};
               end else begin
                  if (ttl_ff[slot_ff] > timer_ff[slot_ff]) begin
                     timer_in[slot_ff] = ttl_ff[slot_ff];
                  end
                  rsp_in = '{ST_PENDING, 3'(slot_ff), cur_ff.byte_start, cur_ff.byte_end,
                             14'd0, 1'b1};
               end
               state_in = S_IDLE;
            end
         end
         S_TICK: begin
            if (in_use_ff[tick_ff] && timer_ff[tick_ff] <= 8'd1) begin
               if (res_free) begin
                  timer_in[tick_ff] = '0;
                  in_use_in[tick_ff] = 1'b0;
                  rsp_valid_in = 1'b1;
                  rsp_in = '{ST_EXPIRED, 3'(tick_ff), 14'd0, 14'd0, 14'd0, !more_after};
                  tick_in = tick_ff + 1'b1;
                  if (tick_ff == SLOT_BITS'(SLOT_COUNT - 1)) begin
                     state_in = S_IDLE;
                  end
               end
            end else begin
               if (in_use_ff[tick_ff]) begin
                  timer_in[tick_ff] = timer_ff[tick_ff] - 1'b1;
               end
               tick_in = tick_ff + 1'b1;
               if (tick_ff == SLOT_BITS'(SLOT_COUNT - 1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tlb_ff <= TIMER_RESET;
         in_use_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < SLOT_COUNT; k++) begin
            timer_ff[k] <= '0;
            dl_ff[k] <= '0;
            ttl_ff[k] <= '0;
            valid_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            tlb_ff <= csr_data;
         end
         in_use_ff <= in_use_in;
         rsp_valid_ff <= rsp_valid_in;
         timer_ff <= timer_in;
         dl_ff <= dl_in;
         ttl_ff <= ttl_in;
         valid_ff <= valid_in;
      end
      cur_ff <= cur_in;
      akey_ff <= akey_in;
      pkey_ff <= pkey_in;
      hw_ff <= hw_in;
      slot_ff <= slot_in;
      word_ff <= word_in;
      need_ff <= need_in;
      complete_ff <= complete_in;
      tick_ff <= tick_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// ===== hw/rtl/irt_checker.sv =====
module irt_checker import irt_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   a_reset_not_full: assert property (@(posedge clock) reset |=> !req_full)
      else $error("request queue full after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("stalled response changed");

   a_single: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.status != ST_EXPIRED |-> rsp_data.last_result)
      else $error("fragment response not marked last");

   a_rlen: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((rsp_data.status == ST_DONE) == (rsp_data.reassembled_length != 14'd0)))
      else $error("reassembled length inconsistent with status");

endmodule

bind ipv4_reassembly_tracker irt_checker u_irt_checker (
   .clock(clock),
   .reset(reset),
   .req_full(req_full),
   .rsp_empty(rsp_empty),
   .rsp_pop(rsp_pop),
   .rsp_data(rsp_data)
);
